>>> rtl/crp_pkg.sv
package crp_pkg;

	// default ring size
	localparam int FRAME_COUNT_DEF = 64;

	// width of the frame index and victim index fields
	localparam int IDX_W = 6;

	// referenced bits are kept eight to a memory row
	localparam int ROW_BITS = 8;
	localparam int OFF_W    = 3;

	// command codes
	localparam logic CMD_TOUCH  = 1'b0;
	localparam logic CMD_VICTIM = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TOUCH_WR,
		ST_SCAN_RD,
		ST_SCAN_EVAL
	} state_t;

	// outcome of searching one row for a clear bit
	typedef struct packed {
		logic                found;
		logic [OFF_W-1:0]    pos;
		logic [ROW_BITS-1:0] wr_data;
	} scan_t;

endpackage

>>> rtl/crp_req_if.sv
interface crp_req_if import crp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [IDX_W-1:0] frame_index;

	modport source (output valid, output cmd, output frame_index, input ready);
	modport sink (input valid, input cmd, input frame_index, output ready);
endinterface

>>> rtl/crp_rsp_if.sv
interface crp_rsp_if import crp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] victim_index;

	modport source (output valid, output victim_index, input ready);
	modport sink (input valid, input victim_index, output ready);
endinterface

>>> rtl/crp_row_scan.sv
module crp_row_scan import crp_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF,
	parameter int ROW_W       = 3
) (
	input  logic [ROW_BITS-1:0] row_data,
	input  logic [ROW_W-1:0]    row,
	input  logic [OFF_W-1:0]    off,
	output scan_t               res
);

	logic [ROW_BITS-1:0] exists;
	logic [ROW_BITS-1:0] cand;
	logic [ROW_BITS-1:0] clr;
	logic [OFF_W-1:0]    pos;

	// slots past the end of the ring in the last row do not exist
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			exists[b] = ((32'(row) << OFF_W) + 32'(b)) < 32'(FRAME_COUNT);
			cand[b]   = exists[b] && (OFF_W'(b) >= off) && !row_data[b];
		end
	end

	// lowest candidate at or after the start offset
	always_comb begin
		pos = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (cand[b]) begin
				pos = OFF_W'(b);
			end
		end
	end

	// clear the set bits passed over on the way
	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			clr[b] = exists[b] && (OFF_W'(b) >= off) && (!(|cand) || (OFF_W'(b) < pos));
		end
		res.found   = |cand;
		res.pos     = pos;
		res.wr_data = row_data & ~clr;
	end

endmodule

>>> rtl/clock_page_replacement.sv
// Second-chance (clock) victim selection over a ring of FRAME_COUNT frame slots.
// A touch word (cmd 0) sets the referenced bit of frame_index and gives no result;
// an index at or beyond FRAME_COUNT is ignored. A victim word (cmd 1) scans from
// the clock hand, clears every set bit it passes, returns the first frame whose
// bit is clear and leaves the hand just past it; a victim is always found, at
// worst early in the second lap. Only the low six bits of the chosen slot are
// returned. The referenced bits live in a single-port-read, single-port-write
// memory of eight bits per row, ROWS = ceil(FRAME_COUNT / 8) rows. A touch reads
// the row, then writes it back. A victim request reads each row that it visits,
// then searches it and writes it back; it visits only the row under the hand
// when that row holds a clear bit at or past the hand, and at most every row once
// and then the hand row a second time when every bit is set. A found victim may
// also wait for the output register to free up. After reset the block clears
// the memory, one row a cycle, before it takes its first word. One word is
// worked on at a time; a finished victim waits in an output register, so the
// block can take the next word while the result is still unclaimed.
module clock_page_replacement import crp_pkg::*; #(
	parameter int FRAME_COUNT = FRAME_COUNT_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	crp_req_if.sink   req,
	crp_rsp_if.source rsp
);

	// ring geometry
	localparam int ROWS  = (FRAME_COUNT + ROW_BITS - 1) / ROW_BITS;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
	localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(ROW_BITS - 1);

	// referenced bit memory
	logic [ROW_BITS-1:0] ref_mem [ROWS];
	logic [ROW_BITS-1:0] rd_data_q;
	logic [ROW_W-1:0]    rd_addr;
	logic [ROW_W-1:0]    wr_addr;
	logic [ROW_BITS-1:0] wr_data;
	logic                mem_we;

	// control state
	state_t              state_q, state_d;
	logic [ROW_W-1:0]    clr_row_q;
	logic [ROW_W-1:0]    hand_row_q;
	logic [OFF_W-1:0]    hand_off_q;
	logic [ROW_W-1:0]    scan_row_q;
	logic [OFF_W-1:0]    scan_off_q;
	logic                out_valid_q;

	// payload registers
	logic [ROW_W-1:0]    touch_row_q;
	logic [OFF_W-1:0]    touch_off_q;
	logic                touch_ok_q;
	logic [IDX_W-1:0]    victim_q;

	// decoded request
	logic [31:0]         req_idx;
	logic [ROW_W-1:0]    touch_row;
	logic                touch_ok;
	logic                accept;

	// scan of the current row
	scan_t               scan;
	logic [31:0]         found_slot;
	logic                out_free;
	logic                load_out;

	assign req_idx   = 32'(req.frame_index);
	assign touch_row = ROW_W'(req_idx >> OFF_W);
	assign touch_ok  = req_idx < 32'(FRAME_COUNT);
	assign accept    = req.valid && req.ready;

	// output slot can take a new victim this cycle
	assign out_free = !out_valid_q || rsp.ready;

	crp_row_scan #(
		.FRAME_COUNT (FRAME_COUNT),
		.ROW_W       (ROW_W)
	) u_row_scan (
		.row_data (rd_data_q),
		.row      (scan_row_q),
		.off      (scan_off_q),
		.res      (scan)
	);

	assign found_slot = (32'(scan_row_q) << OFF_W) | 32'(scan.pos);

	// memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			ref_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= ref_mem[rd_addr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_row_q == ROW_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req.valid) begin
					state_d = (req.cmd == CMD_TOUCH) ? ST_TOUCH_WR : ST_SCAN_EVAL;
				end
			end
			ST_TOUCH_WR: begin
				state_d = ST_IDLE;
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_EVAL;
			end
			ST_SCAN_EVAL: begin
				if (!scan.found) begin
					state_d = ST_SCAN_RD;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs and memory controls
	always_comb begin
		req.ready = 1'b0;
		mem_we    = 1'b0;
		wr_addr   = scan_row_q;
		wr_data   = scan.wr_data;
		rd_addr   = scan_row_q;
		load_out  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we  = 1'b1;
				wr_addr = clr_row_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				// read the touched row, or the row under the hand for a victim
				rd_addr   = (req.cmd == CMD_TOUCH) ? touch_row : hand_row_q;
			end
			ST_TOUCH_WR: begin
				mem_we  = touch_ok_q;
				wr_addr = touch_row_q;
				wr_data = rd_data_q | (ROW_BITS'(1) << touch_off_q);
			end
			ST_SCAN_RD: begin
				rd_addr = scan_row_q;
			end
			ST_SCAN_EVAL: begin
				// hold the row untouched while a found victim waits for the output
				mem_we   = !scan.found || out_free;
				load_out = scan.found && out_free;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_row_q   <= '0;
			hand_row_q  <= '0;
			hand_off_q  <= '0;
			scan_row_q  <= '0;
			scan_off_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR && clr_row_q != ROW_LAST) begin
				clr_row_q <= clr_row_q + ROW_W'(1);
			end
			// a scan starts at the hand
			if (accept) begin
				scan_row_q <= hand_row_q;
				scan_off_q <= hand_off_q;
			end
			// nothing clear in this row: move on to the next, wrapping at the end
			if (state_q == ST_SCAN_EVAL && !scan.found) begin
				scan_row_q <= (scan_row_q == ROW_LAST) ? '0 : scan_row_q + ROW_W'(1);
				scan_off_q <= '0;
			end
			// hand goes just past the victim
			if (load_out) begin
				if (found_slot + 32'd1 == 32'(FRAME_COUNT)) begin
					hand_row_q <= '0;
					hand_off_q <= '0;
				end else if (scan.pos == OFF_LAST) begin
					hand_row_q <= scan_row_q + ROW_W'(1);
					hand_off_q <= '0;
				end else begin
					hand_row_q <= scan_row_q;
					hand_off_q <= scan.pos + OFF_W'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			touch_row_q <= touch_row;
			touch_off_q <= req.frame_index[OFF_W-1:0];
			touch_ok_q  <= touch_ok;
		end
		if (load_out) begin
			victim_q <= found_slot[IDX_W-1:0];
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.victim_index = victim_q;

endmodule
